// ===== hdl/trk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle resample kernel package
// Shared widths, constants and the divider request/response types.
// ----------------------------------------------------------------------------
package trk_pkg;

    localparam int TRK_MAX_TAPS_DEF = 32;

    // Divider widths: numerator, denominator, partial remainder.
    localparam int TRK_NUM_W = 50;
    localparam int TRK_DEN_W = 33;
    localparam int TRK_REM_W = 34;

    // Quotient bits produced in each divider mode.
    localparam int TRK_Q_NARROW = 17;
    localparam int TRK_Q_WIDE   = 33;

    localparam logic [16:0] TRK_ONE = 17'h10000;

    typedef struct packed {
        logic                 start;
        logic                 wide;
        logic [TRK_NUM_W-1:0] num;
        logic [TRK_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [TRK_DEN_W-1:0] quot;
    } t_div_rsp;

endpackage
`default_nettype wire

// ===== hdl/trk_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle resample kernel divider
// Restoring divider, one quotient bit per cycle, 17 or 33 quotient bits.
// ----------------------------------------------------------------------------
module trk_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire trk_pkg::t_div_req i_req,
    output trk_pkg::t_div_rsp      o_rsp
);

    logic [trk_pkg::TRK_REM_W-1:0] r_rem;
    logic [trk_pkg::TRK_DEN_W-1:0] r_sh;
    logic [trk_pkg::TRK_DEN_W-1:0] r_den;
    logic [5:0]                    r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [trk_pkg::TRK_REM_W-1:0] trial;
    logic [trk_pkg::TRK_REM_W-1:0] diff;
    logic                          ge;

    // The caller guarantees that the quotient fits the selected width, so the
    // high part of the numerator is already below the divisor.
    always_comb begin
        trial = {r_rem[trk_pkg::TRK_REM_W-2:0], r_sh[trk_pkg::TRK_DEN_W-1]};
        ge    = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd1);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.wide ? 6'(trk_pkg::TRK_Q_WIDE) : 6'(trk_pkg::TRK_Q_NARROW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den <= i_req.den;
            if (i_req.wide) begin
                r_rem <= trk_pkg::TRK_REM_W'(i_req.num >> trk_pkg::TRK_Q_WIDE);
                r_sh  <= i_req.num[trk_pkg::TRK_DEN_W-1:0];
            end else begin
                r_rem <= trk_pkg::TRK_REM_W'(i_req.num >> trk_pkg::TRK_Q_NARROW);
                r_sh  <= {i_req.num[trk_pkg::TRK_Q_NARROW-1:0],
                          (trk_pkg::TRK_DEN_W - trk_pkg::TRK_Q_NARROW)'(0)};
            end
        end else if (r_busy) begin
            r_rem <= ge ? diff : trial;
            r_sh  <= {r_sh[trk_pkg::TRK_DEN_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_sh;

endmodule
`default_nettype wire

// ===== hdl/triangle_resample_kernel_gen.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle resample kernel generator
// Builds tent FIR taps for a scaler from a ratio and a phase offset.
// ----------------------------------------------------------------------------
// Usage: drive i_ratio (Q8.16) and i_phase_offset (signed Q8.16) and pulse
// start while busy is low; the item is taken at that edge and busy stays high
// until the cycle in which its last result appears. Results come out in tap
// order, each on the o_ ports for exactly one cycle with o_valid high;
// o_last_tap marks the final one. The receiver cannot stall the block.
// All divisions run through one restoring divider that retires one quotient
// bit per cycle, so that divider sets the timing. Each tap takes one divide to
// build it; when downsampling, a reciprocal of the ratio comes first and each
// tap takes one more divide to normalize a nonzero sum. A kernel that exceeds
// MAX_TAPS yields one error result once the tap count has been checked; an
// empty kernel yields no result. Reset is synchronous and returns the
// sequencer to idle; results under way are dropped.
// ----------------------------------------------------------------------------
module triangle_resample_kernel_gen #(
    parameter int MAX_TAPS = trk_pkg::TRK_MAX_TAPS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [23:0] i_ratio,
    input  wire logic signed [23:0] i_phase_offset,
    output logic                    o_valid,
    output logic             [5:0]  o_tap_index,
    output logic             [16:0] o_tap_value,
    output logic signed      [8:0]  o_center_tap,
    output logic             [15:0] o_tap_count,
    output logic                    o_too_many_taps,
    output logic                    o_last_tap
);

    localparam int IW = $clog2(MAX_TAPS);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_RECIP_GO   = 4'd1;
    localparam logic [3:0] S_RECIP_WAIT = 4'd2;
    localparam logic [3:0] S_EDGE       = 4'd3;
    localparam logic [3:0] S_COUNT      = 4'd4;
    localparam logic [3:0] S_CHECK      = 4'd5;
    localparam logic [3:0] S_TAP_GO     = 4'd6;
    localparam logic [3:0] S_TAP_WAIT   = 4'd7;
    localparam logic [3:0] S_RD         = 4'd8;
    localparam logic [3:0] S_RD_DATA    = 4'd9;
    localparam logic [3:0] S_NORM_WAIT  = 4'd10;

    localparam logic signed [8:0] CENTER_ERR = -9'sd1;

    logic [3:0]          r_state, n_state;
    logic [23:0]         r_ratio, n_ratio;
    logic signed [23:0]  r_offs, n_offs;
    logic                r_down, n_down;
    logic [32:0]         r_w, n_w;
    logic signed [19:0]  r_left, n_left;
    logic signed [19:0]  r_right, n_right;
    logic [19:0]         r_cnt, n_cnt;
    logic [15:0]         r_cnt_sat, n_cnt_sat;
    logic [8:0]          r_center, n_center;
    logic signed [9:0]   r_pos, n_pos;
    logic [IW-1:0]       r_idx, n_idx;
    logic [IW-1:0]       r_last, n_last;
    logic [22:0]         r_sum, n_sum;
    logic                r_norm, n_norm;
    logic [16:0]         r_rdata;

    logic                r_o_valid, n_o_valid;
    logic [5:0]          r_o_index, n_o_index;
    logic [16:0]         r_o_value, n_o_value;
    logic [8:0]          r_o_center, n_o_center;
    logic [15:0]         r_o_count, n_o_count;
    logic                r_o_err, n_o_err;
    logic                r_o_last, n_o_last;

    logic [16:0]         r_taps [MAX_TAPS];
    logic                mem_we;
    logic [16:0]         mem_wdata;

    trk_pkg::t_div_req   div_req;
    trk_pkg::t_div_rsp   div_rsp;

    logic [23:0]         ratio_z;
    logic signed [34:0]  e_lo, e_hi;
    logic signed [20:0]  cnt_s;
    logic signed [26:0]  dd;
    logic [25:0]         tap_dist;
    logic [16:0]         q17, tap;
    logic [22:0]         sum_new;

    trk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        ratio_z  = (i_ratio == 24'd0) ? 24'd1 : i_ratio;
        e_lo     = 35'(r_offs) - $signed({2'b00, r_w});
        e_hi     = 35'(r_offs) + $signed({2'b00, r_w}) + 35'sd65535;
        cnt_s    = 21'(r_right) - 21'(r_left) + 21'sd1;
        dd       = 27'($signed({r_pos, 16'h0000})) - 27'(r_offs);
        tap_dist = dd[26] ? 26'(-dd) : 26'(dd);
        q17      = div_rsp.quot[16:0];
        // A quotient of one or more means the position sits on the edge.
        tap      = q17[16] ? 17'd0 : 17'(trk_pkg::TRK_ONE - q17);
        sum_new  = r_sum + 23'(tap);
    end

    always_comb begin
        n_state    = r_state;
        n_ratio    = r_ratio;
        n_offs     = r_offs;
        n_down     = r_down;
        n_w        = r_w;
        n_left     = r_left;
        n_right    = r_right;
        n_cnt      = r_cnt;
        n_cnt_sat  = r_cnt_sat;
        n_center   = r_center;
        n_pos      = r_pos;
        n_idx      = r_idx;
        n_last     = r_last;
        n_sum      = r_sum;
        n_norm     = r_norm;
        n_o_valid  = 1'b0;
        n_o_index  = r_o_index;
        n_o_value  = r_o_value;
        n_o_center = r_o_center;
        n_o_count  = r_o_count;
        n_o_err    = r_o_err;
        n_o_last   = r_o_last;
        mem_we     = 1'b0;
        mem_wdata  = tap;
        div_req    = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_ratio = ratio_z;
                    n_offs  = i_phase_offset;
                    n_down  = (ratio_z[23:16] == 8'd0);
                    n_w     = {9'd0, ratio_z};
                    n_state = (ratio_z[23:16] == 8'd0) ? S_RECIP_GO : S_EDGE;
                end
            end
            S_RECIP_GO: begin
                div_req.start = 1'b1;
                div_req.wide  = 1'b1;
                div_req.num   = {18'd1, 32'd0} + {27'd0, r_ratio[23:1]};
                div_req.den   = {9'd0, r_ratio};
                n_state       = S_RECIP_WAIT;
            end
            S_RECIP_WAIT: begin
                if (div_rsp.done) begin
                    n_w     = div_rsp.quot;
                    n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                // Floor and ceiling of Q.16 values are arithmetic shifts.
                n_left  = 20'(e_lo >>> 16) + 20'sd1;
                n_right = 20'(e_hi >>> 16) - 20'sd1;
                n_state = S_COUNT;
            end
            S_COUNT: begin
                n_cnt     = cnt_s[20] ? 20'd0 : cnt_s[19:0];
                n_cnt_sat = (cnt_s[20] || cnt_s[19:16] == 4'd0) ?
                            (cnt_s[20] ? 16'd0 : cnt_s[15:0]) : 16'hFFFF;
                n_center  = 9'(-r_left);
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                if (r_cnt == 20'd0) begin
                    n_state = S_IDLE;
                end else if (r_cnt > 20'(MAX_TAPS)) begin
                    n_o_valid  = 1'b1;
                    n_o_index  = 6'd0;
                    n_o_value  = 17'd0;
                    n_o_center = CENTER_ERR;
                    n_o_count  = r_cnt_sat;
                    n_o_err    = 1'b1;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_pos   = 10'(r_left);
                    n_idx   = '0;
                    n_last  = IW'(r_cnt - 20'd1);
                    n_sum   = '0;
                    n_state = S_TAP_GO;
                end
            end
            S_TAP_GO: begin
                div_req.start = 1'b1;
                div_req.wide  = 1'b0;
                div_req.num   = {8'd0, tap_dist, 16'h0000} + {18'd0, r_w[32:1]};
                div_req.den   = r_w;
                n_state       = S_TAP_WAIT;
            end
            S_TAP_WAIT: begin
                if (div_rsp.done) begin
                    mem_we = 1'b1;
                    n_sum  = sum_new;
                    if (r_idx == r_last) begin
                        n_idx   = '0;
                        n_norm  = r_down && (sum_new != 23'd0);
                        n_state = S_RD;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_pos   = r_pos + 10'sd1;
                        n_state = S_TAP_GO;
                    end
                end
            end
            S_RD: begin
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                if (r_norm) begin
                    div_req.start = 1'b1;
                    div_req.wide  = 1'b0;
                    div_req.num   = {17'd0, r_rdata, 16'h0000} + {28'd0, r_sum[22:1]};
                    div_req.den   = {10'd0, r_sum};
                    n_state       = S_NORM_WAIT;
                end else begin
                    n_o_valid  = 1'b1;
                    n_o_value  = r_rdata;
                    n_o_index  = 6'(r_idx);
                    n_o_center = r_center;
                    n_o_count  = r_cnt_sat;
                    n_o_err    = 1'b0;
                    n_o_last   = (r_idx == r_last);
                    n_idx      = r_idx + IW'(1);
                    n_state    = (r_idx == r_last) ? S_IDLE : S_RD;
                end
            end
            S_NORM_WAIT: begin
                if (div_rsp.done) begin
                    n_o_valid  = 1'b1;
                    n_o_value  = q17;
                    n_o_index  = 6'(r_idx);
                    n_o_center = r_center;
                    n_o_count  = r_cnt_sat;
                    n_o_err    = 1'b0;
                    n_o_last   = (r_idx == r_last);
                    n_idx      = r_idx + IW'(1);
                    n_state    = (r_idx == r_last) ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ratio    <= n_ratio;
        r_offs     <= n_offs;
        r_down     <= n_down;
        r_w        <= n_w;
        r_left     <= n_left;
        r_right    <= n_right;
        r_cnt      <= n_cnt;
        r_cnt_sat  <= n_cnt_sat;
        r_center   <= n_center;
        r_pos      <= n_pos;
        r_idx      <= n_idx;
        r_last     <= n_last;
        r_sum      <= n_sum;
        r_norm     <= n_norm;
        r_o_index  <= n_o_index;
        r_o_value  <= n_o_value;
        r_o_center <= n_o_center;
        r_o_count  <= n_o_count;
        r_o_err    <= n_o_err;
        r_o_last   <= n_o_last;
    end

    // Tap store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_taps[r_idx] <= mem_wdata;
        end
        r_rdata <= r_taps[r_idx];
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_tap_index     = r_o_index;
    assign o_tap_value     = r_o_value;
    assign o_center_tap    = $signed(r_o_center);
    assign o_tap_count     = r_o_count;
    assign o_too_many_taps = r_o_err;
    assign o_last_tap      = r_o_last;

endmodule
`default_nettype wire
